// ----- rtl/core/bmsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_pkg
// Shared types, codes and default sizes for the band matrix accumulator.
// ----------------------------------------------------------------------------
package bmsa_pkg;

    localparam int DEF_MAX_EQN   = 256;
    localparam int DEF_MAX_SUPER = 8;
    localparam int DEF_MAX_SUB   = 8;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 9;
    localparam int Q16_W     = 32;
    localparam int Q32_W     = 48;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int EQN_W     = 9;
    localparam int BAND_W    = 4;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_EQN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUB   = 2'd2;

    localparam logic signed [Q32_W-1:0] Q_MAX = {1'b0, {(Q32_W-1){1'b1}}};
    localparam logic signed [Q32_W-1:0] Q_MIN = {1'b1, {(Q32_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_RANGE      = 3'd1,
        ST_BAND       = 3'd2,
        ST_ZERO_SCALE = 3'd3,
        ST_READ_OK    = 3'd4,
        ST_CLEARED    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_FETCH,
        S_SUM,
        S_DONE,
        S_CLEAR
    } state_t;

endpackage

// ----- rtl/core/bmsa_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_req_if
// Command channel: valid/ready with add, read and clear items.
// ----------------------------------------------------------------------------
interface bmsa_req_if;
    import bmsa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [INDEX_W-1:0] row_index;
    logic signed [INDEX_W-1:0] col_index;
    logic signed [Q16_W-1:0]   entry_value;
    logic signed [Q16_W-1:0]   scale;

    modport source (output valid, cmd, row_index, col_index, entry_value, scale,
                    input ready);
    modport sink   (input valid, cmd, row_index, col_index, entry_value, scale,
                    output ready);
endinterface

// ----- rtl/core/bmsa_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_rsp_if
// Result channel: valid/ready with status, read value and saturation flag.
// ----------------------------------------------------------------------------
interface bmsa_rsp_if;
    import bmsa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [Q32_W-1:0] read_value;
    logic                    saturated;

    modport source (output valid, status, read_value, saturated, input ready);
    modport sink   (input valid, status, read_value, saturated, output ready);
endinterface

// ----- rtl/core/band_matrix_scatter_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_matrix_scatter_accumulate
// Accumulates scaled entries into a general band matrix store in band layout.
// Add: lookup, fetch, sum, done; done loads the result and writes the sum back.
// Read: lookup, fetch, done; rejected items: lookup, done. Clear: one store
// entry written per cycle over the whole store, then done. A new item is taken
// only in idle, after done has loaded the previous result. Rate is set by the
// read-modify-write through the single store port. Reset: control registers go
// to zero, then a clearing pass of one entry per cycle over the store, req.ready low.
// ----------------------------------------------------------------------------
module band_matrix_scatter_accumulate #(
    parameter int MAX_EQN   = bmsa_pkg::DEF_MAX_EQN,
    parameter int MAX_SUPER = bmsa_pkg::DEF_MAX_SUPER,
    parameter int MAX_SUB   = bmsa_pkg::DEF_MAX_SUB
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmsa_pkg::CFG_W-1:0]     cfg_wdata,
    bmsa_req_if.sink                       req,
    bmsa_rsp_if.source                     rsp
);
    import bmsa_pkg::*;

    localparam int DEPTH  = MAX_EQN * (2 * MAX_SUB + MAX_SUPER + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CALC_W = (ADDR_W > 16) ? ADDR_W : 16;

    state_t state_reg, state_next;

    logic [EQN_W-1:0]  num_eqn_reg;
    logic [BAND_W-1:0] num_super_reg;
    logic [BAND_W-1:0] num_sub_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_last;

    logic [CMD_W-1:0]          cmd_reg;
    logic signed [INDEX_W-1:0] row_reg;
    logic signed [INDEX_W-1:0] col_reg;
    logic signed [Q16_W-1:0]   val_reg;
    logic signed [Q16_W-1:0]   scl_reg;

    logic signed [2*Q16_W-1:0] product;
    logic signed [2*Q16_W-1:0] prod_reg;
    logic signed [2*Q16_W-1:0] prod_biased;
    logic signed [Q32_W-1:0]   rnd_reg;
    logic signed [Q32_W:0]     sum_wide;
    logic signed [Q32_W-1:0]   sum_reg;
    logic                      sat_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      wr_pend_reg;

    logic                      is_add;
    logic                      in_range;
    logic signed [INDEX_W:0]   diff;
    logic [INDEX_W:0]          diff_mag;
    logic                      out_of_band;
    logic [5:0]                ld;
    logic [CALC_W-1:0]         addr_calc;
    logic                      in_store;
    status_t                   loc_status;
    logic                      loc_ok;

    logic                      ram_we;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_addr;
    logic signed [Q32_W-1:0]   ram_wdata;
    logic signed [Q32_W-1:0]   ram_rdata;

    logic                      out_load;
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [Q32_W-1:0]   out_value_reg;
    logic                      out_sat_reg;

    // configuration, clipped to the built size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_eqn_reg   <= '0;
            num_super_reg <= '0;
            num_sub_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_EQN:
                begin
                    num_eqn_reg <= (32'(cfg_wdata) > MAX_EQN) ? EQN_W'(MAX_EQN)
                                                               : cfg_wdata;
                end
                CFG_NUM_SUPER:
                begin
                    num_super_reg <= (32'(cfg_wdata[BAND_W-1:0]) > MAX_SUPER)
                                     ? BAND_W'(MAX_SUPER) : cfg_wdata[BAND_W-1:0];
                end
                CFG_NUM_SUB:
                begin
                    num_sub_reg <= (32'(cfg_wdata[BAND_W-1:0]) > MAX_SUB)
                                   ? BAND_W'(MAX_SUB) : cfg_wdata[BAND_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // address and band checks
    assign is_add   = (cmd_reg == CMD_ADD);
    assign in_range = !row_reg[INDEX_W-1] && !col_reg[INDEX_W-1]
                      && ($unsigned(row_reg) < num_eqn_reg)
                      && ($unsigned(col_reg) < num_eqn_reg);
    assign diff     = (INDEX_W+1)'(row_reg) - (INDEX_W+1)'(col_reg);
    assign diff_mag = diff[INDEX_W] ? $unsigned(-diff) : $unsigned(diff);
    assign out_of_band = diff[INDEX_W] ? (diff_mag > (INDEX_W+1)'(num_super_reg))
                                       : (diff_mag > (INDEX_W+1)'(num_sub_reg));
    assign ld        = 6'({num_sub_reg, 1'b0}) + 6'(num_super_reg) + 6'd1;
    assign addr_calc = CALC_W'(col_reg[INDEX_W-2:0]) * CALC_W'(ld)
                       + CALC_W'(num_sub_reg) + CALC_W'(num_super_reg)
                       + CALC_W'(diff);
    assign in_store  = (32'(addr_calc) < 32'(DEPTH));

    always_comb
    begin
        if (!in_range)
        begin
            loc_status = ST_RANGE;
        end
        else if (out_of_band || !in_store)
        begin
            loc_status = ST_BAND;
        end
        else
        begin
            loc_status = ST_ADDED;
        end
    end

    assign loc_ok = (loc_status == ST_ADDED);

    always_comb
    begin
        if (cmd_reg == CMD_CLEAR)
        begin
            status_next = ST_CLEARED;
        end
        else if (is_add && (scl_reg == '0))
        begin
            status_next = ST_ZERO_SCALE;
        end
        else if (!loc_ok)
        begin
            status_next = loc_status;
        end
        else if (is_add)
        begin
            status_next = ST_ADDED;
        end
        else
        begin
            status_next = ST_READ_OK;
        end
    end

    // arithmetic
    assign product     = val_reg * scl_reg;
    assign prod_biased = prod_reg + (2*Q16_W)'(32768);
    assign sum_wide    = (Q32_W+1)'(ram_rdata) + (Q32_W+1)'(rnd_reg);
    assign clr_last    = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INIT || state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = addr_reg;
        ram_wdata  = sum_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                ram_addr = addr_calc[ADDR_W-1:0];
                if (status_next == ST_CLEARED)
                begin
                    state_next = S_CLEAR;
                end
                else if (status_next == ST_ADDED || status_next == ST_READ_OK)
                begin
                    ram_re     = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = (status_reg == ST_ADDED) ? S_SUM : S_DONE;
            end
            S_SUM:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    ram_we     = wr_pend_reg;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= req.cmd;
            row_reg <= req.row_index;
            col_reg <= req.col_index;
            val_reg <= req.entry_value;
            scl_reg <= req.scale;
        end
        if (state_reg == S_LOOKUP)
        begin
            prod_reg    <= product;
            status_reg  <= status_next;
            addr_reg    <= addr_calc[ADDR_W-1:0];
            wr_pend_reg <= (status_next == ST_ADDED);
            sat_reg     <= 1'b0;
        end
        if (state_reg == S_FETCH)
        begin
            rnd_reg <= prod_biased[2*Q16_W-1:16];
        end
        if (state_reg == S_SUM)
        begin
            if (sum_wide[Q32_W] != sum_wide[Q32_W-1])
            begin
                sum_reg <= sum_wide[Q32_W] ? Q_MIN : Q_MAX;
                sat_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= sum_wide[Q32_W-1:0];
            end
        end
    end

    bmsa_band_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (Q32_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= (status_reg == ST_READ_OK) ? ram_rdata : '0;
            out_sat_reg    <= sat_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.saturated  = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted item did not enter lookup");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_addr) < 32'(DEPTH)))
        else $error("store write beyond depth");

    a_sat_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (!rsp.saturated || rsp.status == ST_ADDED))
        else $error("saturation flagged on a non-add result");

    a_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_READ_OK) |-> (rsp.read_value == '0))
        else $error("read value set on a non-read result");
`endif
endmodule

// ----- rtl/core/bmsa_band_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_band_ram
// Single-port band store, synchronous read into a registered output.
// ----------------------------------------------------------------------------
module bmsa_band_ram #(
    parameter int DEPTH  = 6400,
    parameter int DATA_W = 48,
    parameter int ADDR_W = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        addr,
    input  logic signed [DATA_W-1:0] wdata,
    output logic signed [DATA_W-1:0] rdata
);
    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

// ----- tb/band_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_checker
// Watches the configuration port and both channels of the band matrix
// accumulator. Keeps its own image of the band store and of the register
// settings, predicts the result of every accepted command and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module band_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmsa_pkg::CFG_W-1:0]     cfg_wdata,
    bmsa_req_if                            req,
    bmsa_rsp_if                            rsp,
    output int                             errors,
    output int                             pending
);
    import bmsa_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_EQN * (2 * DEF_MAX_SUB + DEF_MAX_SUPER + 1);

    typedef struct packed {
        status_t                 status;
        logic signed [Q32_W-1:0] value;
        logic                    sat;
    } band_result_t;

    logic signed [Q32_W-1:0] band_image [0:STORE_DEPTH-1];
    int                      eqn_lim;
    int                      super_lim;
    int                      sub_lim;
    band_result_t            awaited [$];
    band_result_t            oldest;

    function automatic status_t locate_entry(input int row, input int col, output int addr);
        int d;
        int ld;
        addr = 0;
        if (row < 0 || col < 0 || row >= eqn_lim || col >= eqn_lim)
            return ST_RANGE;
        d = row - col;
        if (-d > super_lim || d > sub_lim)
            return ST_BAND;
        ld   = 2 * sub_lim + super_lim + 1;
        addr = col * ld + sub_lim + super_lim + d;
        if (addr >= STORE_DEPTH)
            return ST_BAND;
        return ST_ADDED;
    endfunction

    function automatic band_result_t predict_result(
        input logic [CMD_W-1:0]        op,
        input int                      row,
        input int                      col,
        input logic signed [Q16_W-1:0] val,
        input logic signed [Q16_W-1:0] scl
    );
        band_result_t res;
        status_t      loc;
        int           addr;
        longint       prod;
        longint       total;
        res.status = ST_CLEARED;
        res.value  = '0;
        res.sat    = 1'b0;
        if (op == CMD_CLEAR)
        begin
            foreach (band_image[i])
                band_image[i] = '0;
        end
        else if (op == CMD_ADD)
        begin
            if (scl == 0)
                res.status = ST_ZERO_SCALE;
            else
            begin
                loc        = locate_entry(row, col, addr);
                res.status = loc;
                if (loc == ST_ADDED)
                begin
                    // Q32.32 product, round half up to Q32.16
                    prod  = longint'(val) * longint'(scl);
                    total = longint'(band_image[addr]) + ((prod + 64'sd32768) >>> 16);
                    if (total > longint'(Q_MAX))
                    begin
                        total   = longint'(Q_MAX);
                        res.sat = 1'b1;
                    end
                    else if (total < longint'(Q_MIN))
                    begin
                        total   = longint'(Q_MIN);
                        res.sat = 1'b1;
                    end
                    band_image[addr] = total[Q32_W-1:0];
                end
            end
        end
        else
        begin
            loc = locate_entry(row, col, addr);
            if (loc == ST_ADDED)
            begin
                res.status = ST_READ_OK;
                res.value  = band_image[addr];
            end
            else
                res.status = loc;
        end
        return res;
    endfunction

    task automatic flag(input string what, input logic signed [63:0] expv,
                        input logic signed [63:0] act);
        errors++;
        $display("%0t ns: %s expected %0d, actual %0d", $time, what, expv, act);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (band_image[i])
                band_image[i] = '0;
            eqn_lim   = 0;
            super_lim = 0;
            sub_lim   = 0;
            awaited.delete();
            errors    = 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_EQN:
                        eqn_lim = (cfg_wdata > DEF_MAX_EQN) ? DEF_MAX_EQN : int'(cfg_wdata);
                    CFG_NUM_SUPER:
                        super_lim = (cfg_wdata[3:0] > DEF_MAX_SUPER) ? DEF_MAX_SUPER
                                                                    : int'(cfg_wdata[3:0]);
                    CFG_NUM_SUB:
                        sub_lim = (cfg_wdata[3:0] > DEF_MAX_SUB) ? DEF_MAX_SUB
                                                                : int'(cfg_wdata[3:0]);
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                awaited.push_back(predict_result(req.cmd, int'(req.row_index),
                                                 int'(req.col_index),
                                                 req.entry_value, req.scale));
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                    flag("result transfer with none awaited, status", 64'(-1),
                         64'(rsp.status));
                else
                begin
                    oldest = awaited.pop_front();
                    if (rsp.status !== oldest.status)
                        flag("status", 64'(oldest.status), 64'(rsp.status));
                    if (rsp.read_value !== oldest.value)
                        flag("read_value", 64'(oldest.value), 64'(rsp.read_value));
                    if (rsp.saturated !== oldest.sat)
                        flag("saturated", 64'(oldest.sat), 64'(rsp.saturated));
                end
            end
            pending <= awaited.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for band_matrix_scatter_accumulate. A directed run covers the
// value extremes, rounding, saturation both ways, every status code, the
// unused command and a clear. Four random phases follow under different band
// shapes (extremes included, store kept across shape changes) and different
// sender idle and receiver stall rates; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
    import bmsa_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam logic signed [Q16_W-1:0] Q16_ONE = 32'sh0001_0000;
    localparam logic signed [Q16_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q16_W-1:0] Q16_MIN = 32'sh8000_0000;
    localparam logic signed [Q16_W-1:0] Q16_HALF_LSB = 32'sh0000_8000;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_ITEMS   = 480;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   fail_count;
    int                   outstanding;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    int                   eqn_eff = 0;
    int                   super_eff = 0;
    int                   sub_eff = 0;

    bmsa_req_if req ();
    bmsa_rsp_if rsp ();

    band_matrix_scatter_accumulate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    band_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .errors    (fail_count),
        .pending   (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("band_matrix_scatter_accumulate: mismatch");
            $finish;
        end
    end

    task automatic send(
        input logic [CMD_W-1:0]          op,
        input logic signed [INDEX_W-1:0] row,
        input logic signed [INDEX_W-1:0] col,
        input logic signed [Q16_W-1:0]   val,
        input logic signed [Q16_W-1:0]   scl
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= op;
        req.row_index   <= row;
        req.col_index   <= col;
        req.entry_value <= val;
        req.scale       <= scl;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // hold off until every result is back and the store has settled
    task automatic drain;
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] raw_eqn, input logic [CFG_W-1:0] raw_super,
                             input logic [CFG_W-1:0] raw_sub);
        drain();
        cfg_write(CFG_NUM_EQN, raw_eqn);
        cfg_write(CFG_NUM_SUPER, raw_super);
        cfg_write(CFG_NUM_SUB, raw_sub);
        cfg_write(CFG_SPARE, CFG_W'($urandom));
        cfg_we    <= 1'b0;
        eqn_eff   = (raw_eqn > DEF_MAX_EQN) ? DEF_MAX_EQN : int'(raw_eqn);
        super_eff = (raw_super[3:0] > DEF_MAX_SUPER) ? DEF_MAX_SUPER : int'(raw_super[3:0]);
        sub_eff   = (raw_sub[3:0] > DEF_MAX_SUB) ? DEF_MAX_SUB : int'(raw_sub[3:0]);
    endtask

    function automatic logic signed [Q16_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return Q16_MAX;
            1: return Q16_MIN;
            2: return Q16_ONE;
            3: return -Q16_ONE;
            4: return $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item;
        int pick;
        int hot_span;
        int c;
        int r;
        int d;
        int bad;
        logic [CMD_W-1:0]        op;
        logic signed [Q16_W-1:0] val;
        logic signed [Q16_W-1:0] scl;
        pick = $urandom_range(0, 99);
        val  = rand_q16();
        scl  = rand_q16();
        if (scl == 0)
            scl = Q16_ONE;
        // half the traffic lands on a few hot columns so sums build up
        hot_span = (eqn_eff < 4) ? eqn_eff : 4;
        c = $urandom_range(0, 1) ? int'($urandom_range(0, hot_span - 1))
                                 : int'($urandom_range(0, eqn_eff - 1));
        d = int'($urandom_range(0, super_eff + sub_eff)) - super_eff;
        r = c + d;
        if (r < 0 || r >= eqn_eff)
            r = c;
        op = $urandom_range(0, 1) ? CMD_ADD : CMD_READ;
        if (pick < 5)
        begin
            op = CMD_W'($urandom_range(0, 3));
            if (op == CMD_CLEAR)
                op = CMD_UNUSED;
            send(op, INDEX_W'($urandom), INDEX_W'($urandom), $urandom, $urandom);
        end
        else if (pick < 60)
            send(CMD_ADD, INDEX_W'(r), INDEX_W'(c), val, scl);
        else if (pick < 82)
            send(($urandom_range(0, 7) == 0) ? CMD_UNUSED : CMD_READ,
                 INDEX_W'(r), INDEX_W'(c), val, scl);
        else if (pick < 88)
            send(CMD_ADD, INDEX_W'($urandom), INDEX_W'($urandom), val, '0);
        else if (pick < 94)
        begin
            bad = (eqn_eff < DEF_MAX_EQN && $urandom_range(0, 1))
                ? eqn_eff + int'($urandom_range(0, DEF_MAX_EQN - 1 - eqn_eff))
                : -int'($urandom_range(1, DEF_MAX_EQN));
            if ($urandom_range(0, 1))
                send(op, INDEX_W'(bad), INDEX_W'(c), val, scl);
            else
                send(op, INDEX_W'(r), INDEX_W'(bad), val, scl);
        end
        else
        begin
            r = $urandom_range(0, 1) ? c - super_eff - 1 - int'($urandom_range(0, 3))
                                     : c + sub_eff + 1 + int'($urandom_range(0, 3));
            send(op, INDEX_W'(r), INDEX_W'(c), val, scl);
        end
    endtask

    initial
    begin
        int phase_eqn   [4] = '{12, 256, 511, 5};
        int phase_super [4] = '{3, 8, 15, 0};
        int phase_sub   [4] = '{2, 8, 0, 12};
        int phase_idle  [4] = '{0, 82, 0, 32};
        int phase_stall [4] = '{0, 0, 82, 32};

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        req.valid       = 1'b0;
        req.cmd         = CMD_ADD;
        req.row_index   = '0;
        req.col_index   = '0;
        req.entry_value = '0;
        req.scale       = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: no equations in use
        send(CMD_READ, 0, 0, 0, 0);
        configure(8, 2, 1);
        send(CMD_ADD, 0, 0, Q16_MAX, Q16_MAX);
        send(CMD_ADD, 0, 0, Q16_MAX, Q16_MAX);
        send(CMD_READ, 0, 0, 0, 0);
        send(CMD_ADD, 1, 1, Q16_MIN, Q16_MIN);
        repeat (3) send(CMD_ADD, 2, 2, Q16_MIN, Q16_MAX);
        send(CMD_READ, 2, 2, 0, 0);
        send(CMD_ADD, -1, 0, Q16_ONE, 0);
        send(CMD_ADD, -1, 0, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 0, -256, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 8, 0, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 255, 255, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 0, 3, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 2, 0, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 0, 2, -Q16_ONE, Q16_ONE);
        send(CMD_ADD, 1, 0, 1, Q16_HALF_LSB);
        send(CMD_ADD, 7, 6, -1, Q16_HALF_LSB);
        send(CMD_UNUSED, 1, 0, 0, 0);
        send(CMD_READ, 7, 6, 0, 0);
        send(CMD_READ, 0, 2, 0, 0);
        send(CMD_READ, 5, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 0);

        for (int p = 0; p < 4; p++)
        begin
            configure(CFG_W'(phase_eqn[p]), CFG_W'(phase_super[p]), CFG_W'(phase_sub[p]));
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                begin
                    drain();
                    send(CMD_CLEAR, INDEX_W'($urandom), INDEX_W'($urandom),
                         $urandom, $urandom);
                end
                random_item();
            end
        end

        configure(0, 15, 15);
        send(CMD_READ, 0, 0, 0, 0);
        send(CMD_ADD, 0, 0, Q16_ONE, Q16_ONE);
        send(CMD_ADD, 255, -256, Q16_MAX, Q16_MIN);

        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("band_matrix_scatter_accumulate: match");
        else
            $display("band_matrix_scatter_accumulate: mismatch");
        $finish;
    end

endmodule
